@@ src/hmi_frame_command_decoder_core_assert.svh @@
// Assertion macros for the HMI frame command decoder.
// Included by the top level; the including module provides clock and reset.
`ifndef HMI_FRAME_COMMAND_DECODER_CORE_ASSERT_SVH
`define HMI_FRAME_COMMAND_DECODER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define HFCD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hfcd same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define HFCD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hfcd next-cycle check failed");

`else

`define HFCD_ASSERT_NOW(label, ante, cons)
`define HFCD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ src/hfcd_pkg.sv @@
// Shared types and constants of the HMI frame command decoder.
// No dependencies; used by the channel interfaces and the top level.
package hfcd_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned WORD_W     = 16;
   localparam int unsigned CODE_W     = 3;
   localparam int unsigned HEAD_DEPTH = 12;
   localparam int unsigned TAIL_DEPTH = 4;
   localparam int unsigned SP_DEPTH   = 4;

   // Frames longer than this are flagged as overflowed (range 17 to 255).
   localparam logic [BYTE_W-1:0] FRAME_BUF_LEN = 8'd64;
   localparam logic [BYTE_W-1:0] MIN_FRAME_LEN = 8'd5;

   // Frame framing bytes.
   localparam logic [BYTE_W-1:0] HDR_SOF   = 8'hEE;
   localparam logic [BYTE_W-1:0] HDR_CMD   = 8'hB1;
   localparam logic [BYTE_W-1:0] HDR_SUB   = 8'h11;
   localparam logic [BYTE_W-1:0] TAIL_FF   = 8'hFF;
   localparam logic [BYTE_W-1:0] TAIL_FC   = 8'hFC;
   localparam logic [BYTE_W-1:0] TYPE_LOW  = 8'h10;
   localparam logic [BYTE_W-1:0] TYPE_HIGH = 8'h14;
   localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
   localparam logic [BYTE_W-1:0] STATE_ON  = 8'h01;
   localparam logic [BYTE_W-1:0] PAGE_MAIN = 8'h00;
   localparam logic [BYTE_W-1:0] PAGE_SET  = 8'h01;

   // Control ids.
   localparam logic [BYTE_W-1:0] ID_MAIN_POWER = 8'h54;
   localparam logic [BYTE_W-1:0] ID_POWER      = 8'h29;
   localparam logic [BYTE_W-1:0] ID_INV_SW     = 8'h03;
   localparam logic [BYTE_W-1:0] ID_MODE_A     = 8'h04;
   localparam logic [BYTE_W-1:0] ID_MODE_B     = 8'h05;
   localparam logic [BYTE_W-1:0] ID_SPEED_LO   = 8'h0E;
   localparam logic [BYTE_W-1:0] ID_SPEED_MID  = 8'h0F;
   localparam logic [BYTE_W-1:0] ID_SPEED_HI   = 8'h10;
   localparam logic [BYTE_W-1:0] ID_SW_40      = 8'h0D;
   localparam logic [BYTE_W-1:0] ID_SW_80      = 8'h08;
   localparam logic [BYTE_W-1:0] ID_SW_100     = 8'h07;
   localparam logic [BYTE_W-1:0] ID_SW_400     = 8'h06;
   localparam logic [BYTE_W-1:0] ID_TEMP       = 8'h09;
   localparam logic [BYTE_W-1:0] ID_CO2        = 8'h0A;
   localparam logic [BYTE_W-1:0] ID_PM25       = 8'h0B;
   localparam logic [BYTE_W-1:0] ID_VOC        = 8'h0C;

   // Switch word bit masks.
   localparam logic [WORD_W-1:0] SW_SPEED_LO  = 16'h0001;
   localparam logic [WORD_W-1:0] SW_SPEED_MID = 16'h0002;
   localparam logic [WORD_W-1:0] SW_SPEED_HI  = 16'h0004;
   localparam logic [WORD_W-1:0] SW_POWER     = 16'h0010;
   localparam logic [WORD_W-1:0] SW_INV       = 16'h0020;
   localparam logic [WORD_W-1:0] SW_40        = 16'h0040;
   localparam logic [WORD_W-1:0] SW_80        = 16'h0080;
   localparam logic [WORD_W-1:0] SW_100       = 16'h0100;
   localparam logic [WORD_W-1:0] SW_400       = 16'h0400;
   localparam logic [WORD_W-1:0] SW_MODE_A    = 16'h1000;
   localparam logic [WORD_W-1:0] SW_MODE_B    = 16'h2000;

   // Setpoint store slots.
   localparam int unsigned SP_TEMP = 0;
   localparam int unsigned SP_PM25 = 1;
   localparam int unsigned SP_CO2  = 2;
   localparam int unsigned SP_VOC  = 3;

   // Text frame lengths that carry 2, 3 or 4 digits.
   localparam logic [BYTE_W-1:0] LEN_2DIG = 8'd15;
   localparam logic [BYTE_W-1:0] LEN_3DIG = 8'd16;
   localparam logic [BYTE_W-1:0] LEN_4DIG = 8'd17;

   typedef enum logic [CODE_W-1:0] {
      FUNC_INVALID = 3'd0,
      FUNC_BUTTON  = 3'd1,
      FUNC_TEXT    = 3'd2,
      FUNC_CTRL3   = 3'd3,
      FUNC_CTRL4   = 3'd4,
      FUNC_CTRL5   = 3'd5
   } func_code_type;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [WORD_W-1:0] word_type;

endpackage

@@ src/hfcd_req_if.sv @@
// Input byte channel of the HMI frame command decoder.
// Depends on hfcd_pkg for field widths.
interface hfcd_req_if;
   import hfcd_pkg::*;

   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   rx_byte;
   logic                frame_end;

   modport source (output valid, output rx_byte, output frame_end, input ready);
   modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

@@ src/hfcd_rsp_if.sv @@
// Result channel of the HMI frame command decoder.
// Depends on hfcd_pkg for field widths.
interface hfcd_rsp_if;
   import hfcd_pkg::*;

   logic                valid;
   logic                ready;
   logic [CODE_W-1:0]   func_code;
   logic [WORD_W-1:0]   switch_bits;
   logic [WORD_W-1:0]   temp_setpoint;
   logic [WORD_W-1:0]   pm25_setpoint;
   logic [WORD_W-1:0]   co2_setpoint;
   logic [WORD_W-1:0]   voc_setpoint;

   modport source (output valid, output func_code, output switch_bits,
                   output temp_setpoint, output pm25_setpoint, output co2_setpoint,
                   output voc_setpoint, input ready);
   modport sink   (input valid, input func_code, input switch_bits,
                   input temp_setpoint, input pm25_setpoint, input co2_setpoint,
                   input voc_setpoint, output ready);
endinterface

@@ src/hmi_frame_command_decoder_core.sv @@
// HMI frame command decoder, top level.
// Depends on hfcd_pkg, hfcd_req_if, hfcd_rsp_if and the assertion macro header.
//
// Usage:
// The req channel carries one received frame byte per transaction, with
// frame_end marking the last byte of a frame. The rsp channel carries one
// transaction per frame: the function code (0 for an invalid, short,
// overlong or unknown frame) and the switch word and four setpoints as they
// stand after that frame. Bytes that carry no frame end produce nothing.
// A frame's bytes are captured in the frame registers, and the frame is
// decoded into the result register as soon as that register is free.
// Throughput: one byte per cycle while req_ch.ready is high; the frame
// is decoded in one pass of shallow logic between the frame registers and
// the result register, while the next frame's first byte is taken.
// Stalls: a waiting result sits in the result register and bytes keep
// flowing in. Only when a frame is pending and the result register
// is still full and not being taken does req_ch.ready drop for that cycle.
// Reset (synchronous, active high) clears the switch word, the setpoints,
// the frame state and the result valid flag; the block accepts bytes in
// the first cycle after reset.
`include "hmi_frame_command_decoder_core_assert.svh"

module hmi_frame_command_decoder_core (
   input logic          clock,
   input logic          reset,
   hfcd_req_if.sink     req_ch,
   hfcd_rsp_if.source   rsp_ch
);
   import hfcd_pkg::*;

   // Frame capture registers.
   byte_type                  head_ff [HEAD_DEPTH];
   byte_type                  head_in [HEAD_DEPTH];
   byte_type                  tail_ff [TAIL_DEPTH];
   byte_type                  tail_in [TAIL_DEPTH];
   logic [BYTE_W-1:0]         count_ff, count_in;
   logic                      ovf_ff, ovf_in;
   logic                      in_frame_ff, in_frame_in;
   logic                      pend_ff, pend_in;

   // Architectural state.
   word_type                  switch_ff, switch_in;
   word_type                  sp_ff [SP_DEPTH];
   word_type                  sp_in [SP_DEPTH];

   // Result register.
   logic                      rsp_valid_ff, rsp_valid_in;
   func_code_type             code_ff, code_in;
   word_type                  rsp_switch_ff;
   word_type                  rsp_sp_ff [SP_DEPTH];

   logic                      req_fire;
   logic                      out_load;
   logic                      dec_fire;

   // Frame capture side.
   logic                      start;
   logic [BYTE_W-1:0]         base_count;
   logic                      full;

   // Decode side.
   logic                      hdr_ok, tail_ok, type_ok, frame_ok;
   logic                      btn_on;
   byte_type                  ctrl_id;
   word_type                  dig0, dig1, dig2, dig3;
   word_type                  val2, val3, val4;
   word_type                  text_val;
   logic                      text_len_ok;

   function automatic word_type drive(input word_type w, input word_type m, input logic on);
      drive = on ? (w | m) : (w & ~m);
   endfunction

   function automatic word_type digit(input byte_type b);
      digit = {{(WORD_W-BYTE_W){1'b0}}, b} - {{(WORD_W-BYTE_W){1'b0}}, ASCII_ZERO};
   endfunction

   function automatic word_type times10(input word_type v);
      times10 = (v << 3) + (v << 1);
   endfunction

   // Handshake control. A pending frame decodes as soon as the result
   // register can take it; input stalls only while that is blocked.
   assign out_load     = !rsp_valid_ff || rsp_ch.ready;
   assign dec_fire     = pend_ff && out_load;
   assign req_ch.ready = !pend_ff || out_load;
   assign req_fire     = req_ch.valid && req_ch.ready;

   // Byte capture: the first byte of a frame starts from a cleared head
   // buffer and a zero count. Bytes past the buffer length only set the
   // overflow flag; the tail window always shifts.
   always_comb begin
      start       = !in_frame_ff;
      base_count  = start ? '0 : count_ff;
      full        = base_count >= FRAME_BUF_LEN;
      count_in    = full ? base_count : base_count + 8'd1;
      ovf_in      = (start ? 1'b0 : ovf_ff) | full;
      in_frame_in = !req_ch.frame_end;
      for (int i = 0; i < HEAD_DEPTH; i++) begin
         head_in[i] = start ? '0 : head_ff[i];
         if (!full && base_count == BYTE_W'(i)) begin
            head_in[i] = req_ch.rx_byte;
         end
      end
      for (int i = 0; i < TAIL_DEPTH - 1; i++) begin
         tail_in[i] = tail_ff[i+1];
      end
      tail_in[TAIL_DEPTH-1] = req_ch.rx_byte;
      if (req_fire) begin
         pend_in = req_ch.frame_end;
      end else if (dec_fire) begin
         pend_in = 1'b0;
      end else begin
         pend_in = pend_ff;
      end
   end

   // Frame check and digit conversion.
   always_comb begin
      hdr_ok   = head_ff[0] == HDR_SOF && head_ff[1] == HDR_CMD && head_ff[2] == HDR_SUB;
      tail_ok  = tail_ff[0] == TAIL_FF && tail_ff[1] == TAIL_FC &&
                 tail_ff[2] == TAIL_FF && tail_ff[3] == TAIL_FF;
      type_ok  = head_ff[7] >= TYPE_LOW && head_ff[7] <= TYPE_HIGH;
      frame_ok = !ovf_ff && count_ff >= MIN_FRAME_LEN && hdr_ok && tail_ok && type_ok;
      btn_on   = head_ff[9] == STATE_ON;
      ctrl_id  = head_ff[6];

      // Digits are taken modulo 2^16 at every step, as wrapping is exact.
      dig0 = digit(head_ff[8]);
      dig1 = digit(head_ff[9]);
      dig2 = digit(head_ff[10]);
      dig3 = digit(head_ff[11]);
      val2 = times10(dig0) + dig1;
      val3 = times10(val2) + dig2;
      val4 = times10(val3) + dig3;

      text_len_ok = 1'b1;
      if (count_ff == LEN_2DIG) begin
         text_val = val2;
      end else if (count_ff == LEN_3DIG) begin
         text_val = val3;
      end else if (count_ff == LEN_4DIG) begin
         text_val = val4;
      end else begin
         text_val    = val2;
         text_len_ok = 1'b0;
      end
   end

   // Command execution on the frame's end.
   always_comb begin
      switch_in = switch_ff;
      for (int i = 0; i < SP_DEPTH; i++) begin
         sp_in[i] = sp_ff[i];
      end
      code_in = FUNC_INVALID;

      if (frame_ok) begin
         code_in = func_code_type'(head_ff[7][CODE_W-1:0] + 3'd1);
      end

      if (frame_ok && code_in == FUNC_BUTTON &&
          head_ff[3] == PAGE_MAIN && head_ff[5] == PAGE_MAIN) begin
         if (head_ff[4] == PAGE_MAIN) begin
            if (ctrl_id == ID_MAIN_POWER) begin
               switch_in = drive(switch_ff, SW_POWER, btn_on);
            end
         end else if (head_ff[4] == PAGE_SET) begin
            case (ctrl_id)
               ID_POWER:     switch_in = drive(switch_ff, SW_POWER, btn_on);
               ID_INV_SW:    switch_in = drive(switch_ff, SW_INV, !btn_on);
               ID_MODE_A: begin
                  if (btn_on) begin
                     switch_in = (switch_ff & ~SW_MODE_B) | SW_MODE_A;
                  end else begin
                     switch_in = switch_ff & ~SW_MODE_A;
                  end
               end
               ID_MODE_B: begin
                  if (btn_on) begin
                     switch_in = (switch_ff & ~SW_MODE_A) | SW_MODE_B;
                  end else begin
                     switch_in = switch_ff & ~SW_MODE_B;
                  end
               end
               ID_SPEED_LO:
                  switch_in = (switch_ff & ~(SW_SPEED_MID | SW_SPEED_HI)) | SW_SPEED_LO;
               ID_SPEED_MID:
                  switch_in = (switch_ff & ~(SW_SPEED_LO | SW_SPEED_HI)) | SW_SPEED_MID;
               ID_SPEED_HI:
                  switch_in = (switch_ff & ~(SW_SPEED_LO | SW_SPEED_MID)) | SW_SPEED_HI;
               ID_SW_40:     switch_in = drive(switch_ff, SW_40, btn_on);
               ID_SW_80:     switch_in = drive(switch_ff, SW_80, btn_on);
               ID_SW_100:    switch_in = drive(switch_ff, SW_100, btn_on);
               ID_SW_400:    switch_in = drive(switch_ff, SW_400, btn_on);
               default:      switch_in = switch_ff;
            endcase
         end
      end

      if (frame_ok && code_in == FUNC_TEXT && head_ff[3] == PAGE_MAIN &&
          head_ff[4] == PAGE_SET && head_ff[5] == PAGE_MAIN) begin
         case (ctrl_id)
            ID_TEMP: sp_in[SP_TEMP] = val2;
            ID_CO2: begin
               if (text_len_ok) begin
                  sp_in[SP_CO2] = text_val;
               end
            end
            ID_PM25: begin
               if (text_len_ok) begin
                  sp_in[SP_PM25] = text_val;
               end
            end
            ID_VOC: begin
               if (text_len_ok) begin
                  sp_in[SP_VOC] = text_val;
               end
            end
            default: sp_in[SP_TEMP] = sp_ff[SP_TEMP];
         endcase
      end

      rsp_valid_in = dec_fire || (rsp_valid_ff && !rsp_ch.ready);
   end

   // Control and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         in_frame_ff  <= 1'b0;
         pend_ff      <= 1'b0;
         switch_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < TAIL_DEPTH; i++) begin
            tail_ff[i] <= '0;
         end
         for (int i = 0; i < SP_DEPTH; i++) begin
            sp_ff[i] <= '0;
         end
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            count_ff    <= count_in;
            ovf_ff      <= ovf_in;
            in_frame_ff <= in_frame_in;
            for (int i = 0; i < TAIL_DEPTH; i++) begin
               tail_ff[i] <= tail_in[i];
            end
         end
         if (dec_fire) begin
            switch_ff <= switch_in;
            for (int i = 0; i < SP_DEPTH; i++) begin
               sp_ff[i] <= sp_in[i];
            end
         end
      end
   end

   // Payload registers: the head buffer is cleared at every frame start.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int i = 0; i < HEAD_DEPTH; i++) begin
            head_ff[i] <= head_in[i];
         end
      end
      if (dec_fire) begin
         code_ff       <= code_in;
         rsp_switch_ff <= switch_in;
         for (int i = 0; i < SP_DEPTH; i++) begin
            rsp_sp_ff[i] <= sp_in[i];
         end
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.func_code     = code_ff;
   assign rsp_ch.switch_bits   = rsp_switch_ff;
   assign rsp_ch.temp_setpoint = rsp_sp_ff[SP_TEMP];
   assign rsp_ch.pm25_setpoint = rsp_sp_ff[SP_PM25];
   assign rsp_ch.co2_setpoint  = rsp_sp_ff[SP_CO2];
   assign rsp_ch.voc_setpoint  = rsp_sp_ff[SP_VOC];

   // A decoded frame always lands in the result register.
   `HFCD_ASSERT_NEXT(a_decode_loads_result, dec_fire, rsp_valid_ff)
   // The frame registers are never overwritten under a blocked decode.
   `HFCD_ASSERT_NOW(a_no_capture_over_pending, pend_ff && !out_load, !req_fire)
   // The switch word moves only when a frame is decoded.
   `HFCD_ASSERT_NEXT(a_switch_only_on_decode, !reset && !dec_fire, $stable(switch_ff))
   // An overflowed frame has its count pinned at the buffer length.
   `HFCD_ASSERT_NOW(a_overflow_count, ovf_ff, count_ff == FRAME_BUF_LEN)

endmodule

@@ sim/hmi_frame_command_decoder_core_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of hmi_frame_command_decoder_core: directed frames, then random ones.
// Depends on hfcd_pkg, hfcd_req_if, hfcd_rsp_if and the decoder top level.
module hmi_frame_command_decoder_core_test;
   import hfcd_pkg::*;

   // Control type bytes as they sit in byte 7 of a frame.
   localparam byte_type CT_BUTTON = 8'h10;
   localparam byte_type CT_TEXT   = 8'h11;
   localparam byte_type CT_OTHER3 = 8'h12;
   localparam byte_type CT_OTHER4 = 8'h13;
   localparam byte_type CT_OTHER5 = 8'h14;
   localparam byte_type CT_ABOVE  = 8'h15;
   localparam byte_type CT_BELOW  = 8'h0F;
   // High bytes of the screen and control ids are always zero in a valid command.
   localparam byte_type ID_HI     = 8'h00;
   localparam byte_type STATE_OFF = 8'h00;
   localparam byte_type ASCII_NINE = 8'h39;
   localparam word_type DIGIT_BASE = 16'd10;

   localparam int HEAD_KEEP    = 12;
   localparam int DATA_START   = 8;
   localparam int RANDOM_BYTES = 350;
   localparam int QUIET_FROM   = 60;
   localparam int QUIET_UNTIL  = 200;
   localparam int DRAIN_FRAME  = 4;
   localparam int DRAIN_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int ID_POOL_SIZE = 17;

   localparam byte_type ID_POOL [ID_POOL_SIZE] = '{
      ID_MAIN_POWER, ID_POWER, ID_INV_SW, ID_MODE_A, ID_MODE_B, ID_SPEED_LO,
      ID_SPEED_MID, ID_SPEED_HI, ID_SW_40, ID_SW_80, ID_SW_100, ID_SW_400,
      ID_TEMP, ID_CO2, ID_PM25, ID_VOC, 8'h00};

   // One frame to send. Bytes 3 to 7 come from ctl, bytes 8 to 11 from data,
   // the last four bytes are the trailer and anything else is random filler.
   typedef struct {
      int              len;
      logic [39:0]     ctl;
      logic [31:0]     data;
      bit              bad_head;
      bit              bad_tail;
      int              bad_pos;
      byte_type        bad_xor;
      bit              typed;
      func_code_type   code;
   } frame_spec_type;

   typedef struct {
      func_code_type code;
      word_type      switch_word;
      word_type      temp;
      word_type      pm25;
      word_type      co2;
      word_type      voc;
   } frame_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic sink_ready = 1'b0;
   bit   quiet_run = 1'b0;
   int   err_count = 0;
   int   cycle_count = 0;
   int   random_bytes_sent = 0;

   hfcd_req_if req_ch();
   hfcd_rsp_if rsp_ch();

   assign rsp_ch.ready = sink_ready;

   hmi_frame_command_decoder_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // The watchdog ends a run that hangs.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("simulation failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Decoder prediction: the frame registers, the switch word and the
   // setpoints as the block should hold them after each accepted byte.
   // ---------------------------------------------------------------------
   byte_type         dec_head [HEAD_KEEP];
   logic [31:0]      dec_tail = '0;
   byte_type         dec_count = '0;
   bit               dec_overflow = 1'b0;
   bit               dec_in_frame = 1'b0;
   word_type         dec_switch = '0;
   word_type         dec_setpoint [SP_DEPTH];
   frame_result_type expected_results [$];

   initial begin
      foreach (dec_head[k]) dec_head[k] = '0;
      foreach (dec_setpoint[k]) dec_setpoint[k] = '0;
   end

   // Digits start at byte 8; the value wraps modulo 65536 and non-digits are
   // taken as they come.
   function automatic word_type digit_value(int n);
      word_type v;
      v = '0;
      for (int i = 0; i < n; i++)
         v = v * DIGIT_BASE + (word_type'(dec_head[DATA_START + i]) - word_type'(ASCII_ZERO));
      return v;
   endfunction

   function automatic void drive_switch(word_type mask, bit on);
      if (on)
         dec_switch = dec_switch | mask;
      else
         dec_switch = dec_switch & ~mask;
   endfunction

   // Decodes a completed frame, applies its command and returns the code.
   function automatic func_code_type decode_frame();
      func_code_type code;
      bit            on;
      byte_type      id;
      int            slot;
      code = FUNC_INVALID;
      if (dec_overflow || dec_count < MIN_FRAME_LEN)
         return code;
      if (dec_head[0] != HDR_SOF || dec_head[1] != HDR_CMD || dec_head[2] != HDR_SUB)
         return code;
      if (dec_tail != {TAIL_FF, TAIL_FC, TAIL_FF, TAIL_FF})
         return code;
      if (dec_head[7] < TYPE_LOW || dec_head[7] > TYPE_HIGH)
         return code;
      code = func_code_type'(CODE_W'(dec_head[7] - TYPE_LOW + 8'd1));
      on = (dec_head[9] == STATE_ON);
      id = dec_head[6];
      if (code == FUNC_BUTTON && dec_head[3] == ID_HI && dec_head[5] == ID_HI) begin
         if (dec_head[4] == PAGE_MAIN) begin
            if (id == ID_MAIN_POWER) drive_switch(SW_POWER, on);
         end else if (dec_head[4] == PAGE_SET) begin
            case (id)
               ID_POWER:  drive_switch(SW_POWER, on);
               ID_INV_SW: drive_switch(SW_INV, !on);
               ID_MODE_A: begin
                  if (on) begin
                     drive_switch(SW_MODE_B, 1'b0);
                     drive_switch(SW_MODE_A, 1'b1);
                  end else begin
                     drive_switch(SW_MODE_A, 1'b0);
                  end
               end
               ID_MODE_B: begin
                  if (on) begin
                     drive_switch(SW_MODE_B, 1'b1);
                     drive_switch(SW_MODE_A, 1'b0);
                  end else begin
                     drive_switch(SW_MODE_B, 1'b0);
                  end
               end
               // Speed buttons are exclusive and ignore the state byte.
               ID_SPEED_LO: begin
                  drive_switch(SW_SPEED_MID | SW_SPEED_HI, 1'b0);
                  drive_switch(SW_SPEED_LO, 1'b1);
               end
               ID_SPEED_MID: begin
                  drive_switch(SW_SPEED_LO | SW_SPEED_HI, 1'b0);
                  drive_switch(SW_SPEED_MID, 1'b1);
               end
               ID_SPEED_HI: begin
                  drive_switch(SW_SPEED_LO | SW_SPEED_MID, 1'b0);
                  drive_switch(SW_SPEED_HI, 1'b1);
               end
               ID_SW_40:  drive_switch(SW_40, on);
               ID_SW_80:  drive_switch(SW_80, on);
               ID_SW_100: drive_switch(SW_100, on);
               ID_SW_400: drive_switch(SW_400, on);
               default: ;
            endcase
         end
      end
      if (code == FUNC_TEXT && dec_head[3] == ID_HI && dec_head[4] == PAGE_SET
          && dec_head[5] == ID_HI) begin
         slot = -1;
         case (id)
            ID_TEMP: dec_setpoint[SP_TEMP] = digit_value(2);
            ID_CO2:  slot = SP_CO2;
            ID_PM25: slot = SP_PM25;
            ID_VOC:  slot = SP_VOC;
            default: ;
         endcase
         // The frame length says how many digits there are: 15, 16, 17 give 2, 3, 4.
         if (slot >= 0 && dec_count >= LEN_2DIG && dec_count <= LEN_4DIG)
            dec_setpoint[slot] = digit_value(int'(dec_count - LEN_2DIG) + 2);
      end
      return code;
   endfunction

   // Takes one accepted byte; returns 1 with the result when it ends a frame.
   function automatic bit predict_byte(byte_type b, logic last, output frame_result_type res);
      res = '{FUNC_INVALID, '0, '0, '0, '0, '0};
      if (!dec_in_frame) begin
         foreach (dec_head[k]) dec_head[k] = '0;
         dec_count = '0;
         dec_overflow = 1'b0;
         dec_in_frame = 1'b1;
      end
      if (dec_count >= FRAME_BUF_LEN) begin
         dec_overflow = 1'b1;
      end else begin
         if (dec_count < HEAD_KEEP) dec_head[dec_count] = b;
         dec_count = dec_count + 8'd1;
      end
      dec_tail = {dec_tail[23:0], b};
      if (!last)
         return 1'b0;
      dec_in_frame = 1'b0;
      res.code = decode_frame();
      res.switch_word = dec_switch;
      res.temp = dec_setpoint[SP_TEMP];
      res.pm25 = dec_setpoint[SP_PM25];
      res.co2  = dec_setpoint[SP_CO2];
      res.voc  = dec_setpoint[SP_VOC];
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // Frame building and the byte sender.
   // ---------------------------------------------------------------------
   function automatic logic [39:0] ctl_bytes(byte_type page, byte_type id, byte_type ctype);
      return {ID_HI, page, ID_HI, id, ctype};
   endfunction

   function automatic byte_type frame_byte(frame_spec_type s, int i);
      byte_type b;
      int       tail_start;
      tail_start = s.len - int'(TAIL_DEPTH);
      if (s.len >= int'(MIN_FRAME_LEN) && i >= tail_start) begin
         b = (i - tail_start == 1) ? TAIL_FC : TAIL_FF;
         if (s.bad_tail && i - tail_start == s.bad_pos) b = b ^ s.bad_xor;
      end else if (i < 3) begin
         b = (i == 0) ? HDR_SOF : (i == 1) ? HDR_CMD : HDR_SUB;
         if (s.bad_head && i == s.bad_pos) b = b ^ s.bad_xor;
      end else if (i < DATA_START) begin
         b = s.ctl[8*(7-i) +: 8];
      end else if (i < HEAD_KEEP) begin
         b = s.data[8*(11-i) +: 8];
      end else begin
         b = byte_type'($urandom);
      end
      return b;
   endfunction

   // Drives one byte and returns once the block has taken it. Ready is
   // sampled at the falling edge, where it holds the value seen at the next
   // rising edge.
   task automatic send_byte(byte_type b, logic last);
      bit took;
      while (!quiet_run && $urandom_range(99) < 23) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.rx_byte <= b;
      req_ch.frame_end <= last;
      forever begin
         @(negedge clock);
         took = req_ch.ready;
         @(posedge clock);
         if (took) break;
      end
   endtask

   task automatic send_frame(frame_spec_type s);
      frame_result_type res;
      byte_type         b;
      logic             last;
      for (int i = 0; i < s.len; i++) begin
         b = frame_byte(s, i);
         last = (i == s.len - 1);
         send_byte(b, last);
         if (predict_byte(b, last, res)) begin
            // Rows with a hand-written code override the predicted one.
            if (s.typed) res.code = s.code;
            expected_results.push_back(res);
         end
      end
   endtask

   function automatic byte_type random_digit();
      if ($urandom_range(9) == 0)
         return byte_type'($urandom);
      return ASCII_ZERO + byte_type'($urandom_range(9));
   endfunction

   // Mostly well-formed button and text commands with random content; the
   // rest is noise, broken framing, short and overlong frames.
   function automatic frame_spec_type random_frame();
      frame_spec_type s;
      int             pick;
      byte_type       page;
      byte_type       id;
      byte_type       ctype;
      pick = $urandom_range(99);
      page = ($urandom_range(7) == 0) ? PAGE_MAIN : PAGE_SET;
      id = ID_POOL[$urandom_range(ID_POOL_SIZE - 1)];
      if ($urandom_range(11) == 0) id = byte_type'($urandom);
      if (pick < 45) ctype = CT_BUTTON;
      else if (pick < 80) ctype = CT_TEXT;
      else if (pick < 90) ctype = CT_OTHER3 + byte_type'($urandom_range(2));
      else ctype = byte_type'($urandom);
      s.ctl = ctl_bytes(page, id, ctype);
      if ($urandom_range(19) == 0) s.ctl[39:32] = byte_type'($urandom);
      if ($urandom_range(19) == 0) s.ctl[23:16] = byte_type'($urandom);
      if ($urandom_range(19) == 0) s.ctl[31:24] = byte_type'($urandom);
      s.data = {random_digit(), random_digit(), random_digit(), random_digit()};
      if (ctype == CT_BUTTON) begin
         s.data[23:16] = ($urandom_range(9) == 0) ? byte_type'($urandom)
                         : ($urandom_range(1) ? STATE_ON : STATE_OFF);
         s.len = ($urandom_range(6) == 0) ? $urandom_range(12, 20) : 14;
      end else begin
         s.len = ($urandom_range(6) == 0) ? $urandom_range(12, 20) : $urandom_range(15, 17);
      end
      s.bad_head = ($urandom_range(24) == 0);
      s.bad_tail = ($urandom_range(24) == 0);
      s.bad_pos = $urandom_range(2);
      s.bad_xor = byte_type'($urandom_range(1, 255));
      s.typed = 1'b0;
      s.code = FUNC_INVALID;
      pick = $urandom_range(99);
      if (pick < 3) begin
         s.len = $urandom_range(1, 4);
      end else if (pick < 5) begin
         s.len = $urandom_range(int'(FRAME_BUF_LEN) - 1, int'(FRAME_BUF_LEN) + 4);
      end else if (pick < 9) begin
         s.ctl = {$urandom, 8'($urandom)};
         s.data = $urandom;
         s.len = $urandom_range(5, 20);
      end
      return s;
   endfunction

   // ---------------------------------------------------------------------
   // Result side: random back-pressure and the in-order comparison.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      sink_ready <= (!quiet_run && $urandom_range(99) < 23) ? 1'b0 : 1'b1;
   end

   task automatic check_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         err_count++;
      end
   endtask

   always @(posedge clock) begin
      frame_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_results.size() == 0) begin
            $error("result with none expected: func_code %0d", rsp_ch.func_code);
            err_count++;
         end else begin
            want = expected_results.pop_front();
            check_field("func_code", WORD_W'(want.code), WORD_W'(rsp_ch.func_code));
            check_field("switch_bits", want.switch_word, rsp_ch.switch_bits);
            check_field("temp_setpoint", want.temp, rsp_ch.temp_setpoint);
            check_field("pm25_setpoint", want.pm25, rsp_ch.pm25_setpoint);
            check_field("co2_setpoint", want.co2, rsp_ch.co2_setpoint);
            check_field("voc_setpoint", want.voc, rsp_ch.voc_setpoint);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus. The directed table covers most controls, the text lengths,
   // wrap of non-digit text, all type codes, broken framing, short and
   // overlong frames; the random part follows.
   // ---------------------------------------------------------------------
   frame_spec_type directed_frames [];

   initial begin
      int frame_index;
      req_ch.valid <= 1'b0;
      req_ch.rx_byte <= '0;
      req_ch.frame_end <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      directed_frames = '{
         // Short frames right after reset: code 0 with all registers zero.
         '{3, ctl_bytes(PAGE_SET, ID_TEMP, CT_TEXT), 32'h0, 0, 0, 0, 8'h00, 1, FUNC_INVALID},
         '{1, ctl_bytes(PAGE_SET, ID_TEMP, CT_TEXT), 32'h0, 0, 0, 0, 8'h00, 1, FUNC_INVALID},
         // Minimum length, but the trailer overwrites the header.
         '{5, ctl_bytes(PAGE_SET, ID_TEMP, CT_TEXT), 32'h0, 0, 0, 0, 8'h00, 1, FUNC_INVALID},
         '{14, ctl_bytes(PAGE_MAIN, ID_MAIN_POWER, CT_BUTTON), {STATE_OFF, STATE_ON, 16'h0},
           0, 0, 0, 8'h00, 1, FUNC_BUTTON},
         '{14, ctl_bytes(PAGE_SET, ID_POWER, CT_BUTTON), {STATE_OFF, STATE_OFF, 16'h0},
           0, 0, 0, 8'h00, 1, FUNC_BUTTON},
         // Speed buttons ignore the state byte.
         '{14, ctl_bytes(PAGE_SET, ID_SPEED_HI, CT_BUTTON), 32'hFFFF_FFFF,
           0, 0, 0, 8'h00, 1, FUNC_BUTTON},
         '{14, ctl_bytes(PAGE_SET, ID_SPEED_LO, CT_BUTTON), 32'h0, 0, 0, 0, 8'h00, 1, FUNC_BUTTON},
         '{14, ctl_bytes(PAGE_SET, ID_MODE_A, CT_BUTTON), {STATE_OFF, STATE_ON, 16'h0},
           0, 0, 0, 8'h00, 1, FUNC_BUTTON},
         '{14, ctl_bytes(PAGE_SET, ID_MODE_B, CT_BUTTON), {STATE_OFF, STATE_ON, 16'h0},
           0, 0, 0, 8'h00, 1, FUNC_BUTTON},
         '{14, ctl_bytes(PAGE_SET, ID_MODE_A, CT_BUTTON), {STATE_OFF, STATE_OFF, 16'h0},
           0, 0, 0, 8'h00, 1, FUNC_BUTTON},
         '{14, ctl_bytes(PAGE_SET, ID_INV_SW, CT_BUTTON), {STATE_OFF, STATE_OFF, 16'h0},
           0, 0, 0, 8'h00, 1, FUNC_BUTTON},
         '{14, ctl_bytes(PAGE_SET, ID_SW_400, CT_BUTTON), {STATE_OFF, STATE_ON, 16'h0},
           0, 0, 0, 8'h00, 1, FUNC_BUTTON},
         '{20, ctl_bytes(PAGE_SET, ID_SW_40, CT_BUTTON), {STATE_OFF, STATE_ON, 16'h0},
           0, 0, 0, 8'h00, 0, FUNC_INVALID},
         // Text: two, four, three and four digits, the three-digit one all non-digits.
         '{15, ctl_bytes(PAGE_SET, ID_TEMP, CT_TEXT), {ASCII_NINE, ASCII_NINE, 16'h0},
           0, 0, 0, 8'h00, 1, FUNC_TEXT},
         '{17, ctl_bytes(PAGE_SET, ID_CO2, CT_TEXT), {4{ASCII_NINE}}, 0, 0, 0, 8'h00, 0, FUNC_INVALID},
         '{16, ctl_bytes(PAGE_SET, ID_PM25, CT_TEXT), 32'hFFFF_FFFF, 0, 0, 0, 8'h00, 0, FUNC_INVALID},
         '{17, ctl_bytes(PAGE_SET, ID_VOC, CT_TEXT), 32'h3132_3334, 0, 0, 0, 8'h00, 0, FUNC_INVALID},
         // A text frame of the wrong length, and one on the main page, change nothing.
         '{18, ctl_bytes(PAGE_SET, ID_CO2, CT_TEXT), 32'h3535_3535, 0, 0, 0, 8'h00, 0, FUNC_INVALID},
         '{15, ctl_bytes(PAGE_MAIN, ID_TEMP, CT_TEXT), 32'h3131_0000, 0, 0, 0, 8'h00, 0, FUNC_INVALID},
         '{14, ctl_bytes(PAGE_SET, ID_TEMP, CT_OTHER3), 32'h0, 0, 0, 0, 8'h00, 1, FUNC_CTRL3},
         '{14, ctl_bytes(PAGE_SET, ID_TEMP, CT_OTHER4), 32'h0, 0, 0, 0, 8'h00, 1, FUNC_CTRL4},
         '{14, ctl_bytes(PAGE_SET, ID_TEMP, CT_OTHER5), 32'h0, 0, 0, 0, 8'h00, 1, FUNC_CTRL5},
         '{14, ctl_bytes(PAGE_SET, ID_TEMP, CT_ABOVE), 32'h0, 0, 0, 0, 8'h00, 1, FUNC_INVALID},
         '{14, ctl_bytes(PAGE_SET, ID_TEMP, CT_BELOW), 32'h0, 0, 0, 0, 8'h00, 1, FUNC_INVALID},
         '{14, ctl_bytes(PAGE_SET, ID_POWER, CT_BUTTON), {STATE_OFF, STATE_ON, 16'h0},
           1, 0, 1, 8'h40, 1, FUNC_INVALID},
         '{14, ctl_bytes(PAGE_SET, ID_POWER, CT_BUTTON), {STATE_OFF, STATE_ON, 16'h0},
           0, 1, 2, 8'h80, 1, FUNC_INVALID},
         // Overlong frame, then a short one after it.
         '{int'(FRAME_BUF_LEN) + 6, ctl_bytes(PAGE_SET, ID_POWER, CT_BUTTON),
           {STATE_OFF, STATE_ON, 16'h0}, 0, 0, 0, 8'h00, 1, FUNC_INVALID},
         '{4, ctl_bytes(PAGE_SET, ID_POWER, CT_BUTTON), 32'h0, 0, 0, 0, 8'h00, 1, FUNC_INVALID},
         // Frames where the trailer takes the place of the payload bytes.
         '{12, ctl_bytes(PAGE_SET, ID_TEMP, CT_TEXT), 32'h0, 0, 0, 0, 8'h00, 0, FUNC_INVALID},
         '{12, ctl_bytes(PAGE_SET, ID_SW_80, CT_BUTTON), 32'h0, 0, 0, 0, 8'h00, 0, FUNC_INVALID}
      };
      foreach (directed_frames[k])
         send_frame(directed_frames[k]);

      frame_index = 0;
      while (random_bytes_sent < RANDOM_BYTES) begin
         frame_random_send: begin
            frame_spec_type s;
            s = random_frame();
            // A stretch where neither side holds back.
            quiet_run = (random_bytes_sent >= QUIET_FROM && random_bytes_sent < QUIET_UNTIL);
            // Hold off once until the block has drained completely.
            if (frame_index == DRAIN_FRAME) begin
               req_ch.valid <= 1'b0;
               while (expected_results.size() != 0) @(posedge clock);
            end
            send_frame(s);
            random_bytes_sent += s.len;
            frame_index++;
         end
      end
      quiet_run = 1'b0;
      req_ch.valid <= 1'b0;

      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
